[design/assert_macros.svh]
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define DSS_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define DSS_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DSS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define DSS_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

[design/dss_pkg.sv]
// Types and constants of the disk seek scheduler
`default_nettype none
package dss_pkg;

  localparam int REQ_W     = 16;
  localparam int TOT_W     = 22;
  localparam int CC_W      = 17;
  localparam int MODE_W    = 2;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  // mode codes; anything else behaves as first come first served
  localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CSCAN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_DOWN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_HEAD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CYL_COUNT  = 2'd3;

  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT,
    S_FC_WAIT,
    S_FC_SERVE,
    S_SC_START,
    S_SC_RUN,
    S_SC_PICK,
    S_JUMP,
    S_TURN,
    S_TOTAL
  } state_e;

  typedef enum logic [1:0] {
    TGT_DATA,
    TGT_BEST,
    TGT_TOP,
    TGT_ZERO
  } tgt_e;

  typedef struct packed {
    logic store;
    logic init;
    logic ptr_clr;
    logic ptr_inc;
    logic scan_start;
    logic phase_set;
    logic phase_hi;
    logic phase_asc;
    logic move;
    tgt_e tgt;
    logic emit_srv;
    logic emit_tot;
    logic take_best;
    logic clr_cnt;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic scan_last;
    logic best_vld;
    logic fc_last;
  } status_t;

endpackage
`default_nettype wire

[design/dss_datapath.sv]
// Request store, selection scan, head tracking and result register
`default_nettype none
module dss_datapath
  import dss_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32,
  parameter int CYL_BITS    = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire cmd_t          cmd_i,
  output status_t            status_o,
  input  wire [REQ_W-1:0]    request_cylinder_i,
  input  wire                sweep_down_i,
  input  wire [REQ_W-1:0]    start_head_i,
  input  wire [CC_W-1:0]     cylinder_count_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic [REQ_W-1:0]   served_cylinder_o,
  output logic [TOT_W-1:0]   seek_total_o,
  output logic               is_total_o,
  output logic               last_o
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int KW = CYL_BITS + AW;
  localparam logic [CC_W-1:0] LIM = CC_W'(1) << CYL_BITS;

  logic [CYL_BITS-1:0] mem [QUEUE_DEPTH];
  logic [CYL_BITS-1:0] rd_data_q;

  logic [CW-1:0]       cnt_q;
  logic [AW-1:0]       rd_ptr_q;
  logic                scan_busy_q, cmp_vld_q;
  logic [AW-1:0]       cmp_idx_q;
  logic                best_vld_q, have_prev_q, phase_hi_q, phase_asc_q;
  logic [KW-1:0]       best_key_q, prev_key_q;
  logic [CYL_BITS-1:0] head_q, base_q;
  logic [TOT_W-1:0]    acc_q;
  logic                out_valid_q;

  logic [CC_W-1:0]     top_full;
  logic [CYL_BITS-1:0] top_cyl, req_clamp, head_clamp, tgt_val, seek_len;
  logic [KW-1:0]       cand_key;
  logic                in_hi, cand_ok, ptr_end, slot_free;

  // highest cylinder, with count of zero as one and oversize counts limited
  always_comb begin
    if (cylinder_count_i == '0) begin
      top_full = '0;
    end else if (cylinder_count_i > LIM) begin
      top_full = LIM - 1'b1;
    end else begin
      top_full = cylinder_count_i - 1'b1;
    end
  end
  assign top_cyl    = top_full[CYL_BITS-1:0];
  assign req_clamp  = ({1'b0, request_cylinder_i} > top_full) ? top_cyl
                                                             : request_cylinder_i[CYL_BITS-1:0];
  assign head_clamp = ({1'b0, start_head_i} > top_full) ? top_cyl
                                                       : start_head_i[CYL_BITS-1:0];

  assign ptr_end = (CW'(rd_ptr_q) == (cnt_q - 1'b1));

  // key carries the index so equal cylinders stay distinct
  assign cand_key = {rd_data_q, cmp_idx_q};
  assign in_hi    = sweep_down_i ? (rd_data_q > base_q) : (rd_data_q >= base_q);
  always_comb begin
    cand_ok = (in_hi == phase_hi_q);
    if (have_prev_q) begin
      cand_ok = cand_ok && (phase_asc_q ? (cand_key > prev_key_q) : (cand_key < prev_key_q));
    end
    if (best_vld_q) begin
      cand_ok = cand_ok && (phase_asc_q ? (cand_key < best_key_q) : (cand_key > best_key_q));
    end
  end

  always_comb begin
    case (cmd_i.tgt)
      TGT_DATA: tgt_val = rd_data_q;
      TGT_BEST: tgt_val = best_key_q[KW-1:AW];
      TGT_TOP:  tgt_val = top_cyl;
      TGT_ZERO: tgt_val = '0;
      default:  tgt_val = '0;
    endcase
  end
  assign seek_len = (tgt_val > head_q) ? (tgt_val - head_q) : (head_q - tgt_val);

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && (cnt_q < CW'(QUEUE_DEPTH))) begin
      mem[cnt_q[AW-1:0]] <= req_clamp;
    end
    rd_data_q <= mem[rd_ptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_ptr_q    <= '0;
      scan_busy_q <= 1'b0;
      cmp_vld_q   <= 1'b0;
      best_vld_q  <= 1'b0;
      have_prev_q <= 1'b0;
      phase_hi_q  <= 1'b0;
      phase_asc_q <= 1'b0;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      acc_q       <= '0;
    end else begin
      if (cmd_i.clr_cnt) begin
        cnt_q <= '0;
      end else if (cmd_i.store && (cnt_q < CW'(QUEUE_DEPTH))) begin
        cnt_q <= cnt_q + 1'b1;
      end

      cmp_vld_q <= scan_busy_q;
      if (cmd_i.ptr_clr) begin
        rd_ptr_q <= '0;
      end else if (cmd_i.scan_start) begin
        rd_ptr_q    <= '0;
        scan_busy_q <= 1'b1;
      end else if (scan_busy_q) begin
        if (ptr_end) begin
          scan_busy_q <= 1'b0;
        end else begin
          rd_ptr_q <= rd_ptr_q + 1'b1;
        end
      end else if (cmd_i.ptr_inc) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end

      if (cmd_i.scan_start) begin
        best_vld_q <= 1'b0;
      end else if (cmp_vld_q && cand_ok) begin
        best_vld_q <= 1'b1;
      end

      if (cmd_i.phase_set) begin
        have_prev_q <= 1'b0;
        phase_hi_q  <= cmd_i.phase_hi;
        phase_asc_q <= cmd_i.phase_asc;
      end else if (cmd_i.take_best) begin
        have_prev_q <= 1'b1;
      end

      if (cmd_i.init) begin
        head_q <= head_clamp;
        acc_q  <= '0;
      end else if (cmd_i.move) begin
        head_q <= tgt_val;
        acc_q  <= acc_q + TOT_W'(seek_len);
      end

      if (cmd_i.emit_srv || cmd_i.emit_tot) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= rd_ptr_q;
    if (cmp_vld_q && cand_ok) begin
      best_key_q <= cand_key;
    end
    if (cmd_i.take_best) begin
      prev_key_q <= best_key_q;
    end
    if (cmd_i.init) begin
      base_q <= head_clamp;
    end
    if (cmd_i.emit_srv) begin
      served_cylinder_o <= REQ_W'(tgt_val);
      seek_total_o      <= '0;
      is_total_o        <= 1'b0;
      last_o            <= 1'b0;
    end else if (cmd_i.emit_tot) begin
      served_cylinder_o <= '0;
      seek_total_o      <= acc_q;
      is_total_o        <= 1'b1;
      last_o            <= 1'b1;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.slot_free = slot_free;
  assign status_o.scan_last = cmp_vld_q && !scan_busy_q;
  assign status_o.best_vld  = best_vld_q;
  assign status_o.fc_last   = ptr_end;

endmodule
`default_nettype wire

[design/dss_ctrl.sv]
// Sequencer for loading, ordering passes and result emission
`default_nettype none
module dss_ctrl
  import dss_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire              last_request_i,
  input  wire [MODE_W-1:0] mode_i,
  input  wire              sweep_down_i,
  input  wire status_t     status_i,
  output cmd_t             cmd_o
);

  state_e state_q, state_d;
  logic   phase2_q, phase2_d;
  logic   jumped_q, jumped_d;
  logic   is_scan, is_cscan, accept;

  assign is_scan    = (mode_i == MODE_SCAN) || (mode_i == MODE_CSCAN);
  assign is_cscan   = (mode_i == MODE_CSCAN);
  assign in_ready_o = (state_q == S_LOAD);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      phase2_q <= 1'b0;
      jumped_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase2_q <= phase2_d;
      jumped_q <= jumped_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    phase2_d  = phase2_q;
    jumped_d  = jumped_q;
    cmd_o     = '0;
    cmd_o.tgt = TGT_DATA;
    case (state_q)
      S_LOAD: begin
        cmd_o.store = accept;
        if (accept && last_request_i) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.init      = 1'b1;
        cmd_o.ptr_clr   = 1'b1;
        cmd_o.phase_set = 1'b1;
        cmd_o.phase_hi  = !sweep_down_i;
        cmd_o.phase_asc = !sweep_down_i;
        phase2_d        = 1'b0;
        jumped_d        = 1'b0;
        state_d         = is_scan ? S_SC_START : S_FC_WAIT;
      end
      S_FC_WAIT: begin
        state_d = S_FC_SERVE;
      end
      S_FC_SERVE: begin
        if (status_i.slot_free) begin
          cmd_o.move     = 1'b1;
          cmd_o.tgt      = TGT_DATA;
          cmd_o.emit_srv = 1'b1;
          cmd_o.ptr_inc  = 1'b1;
          state_d        = status_i.fc_last ? S_TOTAL : S_FC_WAIT;
        end
      end
      S_SC_START: begin
        cmd_o.scan_start = 1'b1;
        state_d          = S_SC_RUN;
      end
      S_SC_RUN: begin
        if (status_i.scan_last) begin
          state_d = S_SC_PICK;
        end
      end
      S_SC_PICK: begin
        if (status_i.best_vld) begin
          // circular scan jumps to the far end before the second pass
          if (phase2_q && is_cscan && !jumped_q) begin
            state_d = S_JUMP;
          end else if (status_i.slot_free) begin
            cmd_o.move      = 1'b1;
            cmd_o.tgt       = TGT_BEST;
            cmd_o.emit_srv  = 1'b1;
            cmd_o.take_best = 1'b1;
            state_d         = S_SC_START;
          end
        end else begin
          state_d = phase2_q ? S_TOTAL : S_TURN;
        end
      end
      S_JUMP: begin
        cmd_o.move = 1'b1;
        cmd_o.tgt  = sweep_down_i ? TGT_TOP : TGT_ZERO;
        jumped_d   = 1'b1;
        state_d    = S_SC_PICK;
      end
      S_TURN: begin
        cmd_o.move      = 1'b1;
        cmd_o.tgt       = sweep_down_i ? TGT_ZERO : TGT_TOP;
        cmd_o.phase_set = 1'b1;
        cmd_o.phase_hi  = sweep_down_i;
        cmd_o.phase_asc = sweep_down_i ? (mode_i == MODE_SCAN) : is_cscan;
        phase2_d        = 1'b1;
        jumped_d        = 1'b0;
        state_d         = S_SC_START;
      end
      S_TOTAL: begin
        if (status_i.slot_free) begin
          cmd_o.emit_tot = 1'b1;
          cmd_o.clr_cnt  = 1'b1;
          state_d        = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

[design/disk_seek_scheduler.sv]
// Disk seek scheduler top level: configuration registers, controller and datapath
//
// Requests enter on the in_valid_i/in_ready_o channel, one per cycle while loading.
// Each request cylinder is clamped to the top cylinder and stored; the request
// carrying last_request_i closes the batch. Requests beyond QUEUE_DEPTH are dropped.
// Results leave on out_valid_o/out_ready_i: one item per stored request in service
// order, then one total item with seek_total_o, is_total_o and last_o set.
// In first come first served mode each result takes a memory read and a serve state.
// In SCAN and C-SCAN every result is found by a full pass over the request store through
// its single read port. The turn at the end and the C-SCAN jump take a state each.
// in_ready_o is low from the closing request until the total item is in the output
// register; the next batch then loads while that item still waits to be taken.
// A stalled receiver holds the output register and the sequencer waits on it.
// Configuration (index 0 mode, 1 sweep_down, 2 start_head, 3 cylinder_count) is
// written through cfg_we_i; reset gives FCFS, upward sweep, head 0 and 65536 cylinders,
// an empty store and an idle output.
`default_nettype none
`include "assert_macros.svh"
module disk_seek_scheduler
  import dss_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32,
  parameter int CYL_BITS    = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [CFG_W-1:0]     cfg_wdata_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire [REQ_W-1:0]     request_cylinder_i,
  input  wire                 last_request_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic [REQ_W-1:0]    served_cylinder_o,
  output logic [TOT_W-1:0]    seek_total_o,
  output logic                is_total_o,
  output logic                last_o
);

  logic [MODE_W-1:0] mode_q;
  logic              sweep_down_q;
  logic [REQ_W-1:0]  start_head_q;
  logic [CC_W-1:0]   cyl_count_q;
  cmd_t              cmd;
  status_t           status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= '0;
      sweep_down_q <= 1'b0;
      start_head_q <= '0;
      cyl_count_q  <= CC_W'(1) << REQ_W;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:       mode_q       <= cfg_wdata_i[MODE_W-1:0];
        REG_SWEEP_DOWN: sweep_down_q <= cfg_wdata_i[0];
        REG_START_HEAD: start_head_q <= cfg_wdata_i[REQ_W-1:0];
        REG_CYL_COUNT:  cyl_count_q  <= cfg_wdata_i[CC_W-1:0];
        default: ;
      endcase
    end
  end

  dss_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .last_request_i (last_request_i),
    .mode_i         (mode_q),
    .sweep_down_i   (sweep_down_q),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  dss_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CYL_BITS    (CYL_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .request_cylinder_i (request_cylinder_i),
    .sweep_down_i       (sweep_down_q),
    .start_head_i       (start_head_q),
    .cylinder_count_i   (cyl_count_q),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .served_cylinder_o  (served_cylinder_o),
    .seek_total_o       (seek_total_o),
    .is_total_o         (is_total_o),
    .last_o             (last_o)
  );

  // closing request stops loading until the batch has been emitted
  `DSS_ASSERT_NXT(a_close_stops_load, clk_i, rst_ni,
                  in_valid_i && in_ready_o && last_request_i, !in_ready_o)
  // results are only written into a free output register
  `DSS_ASSERT_IMP(a_emit_slot_free, clk_i, rst_ni,
                  cmd.emit_srv || cmd.emit_tot, status.slot_free)
  `DSS_ASSERT_NXT(a_total_shown, clk_i, rst_ni,
                  cmd.emit_tot, out_valid_o && is_total_o && last_o)
  `DSS_ASSERT_IMP(a_total_format, clk_i, rst_ni,
                  out_valid_o && is_total_o, last_o && (served_cylinder_o == '0))

endmodule
`default_nettype wire
